[rtl/mbe_pkg.sv]
`timescale 1ns / 1ps

package mbe_pkg;

	localparam int GRID_SIZE = 512;
	localparam int IDX_W     = $clog2(GRID_SIZE);
	localparam int Q_W       = 32;
	localparam int PROD_W    = 2 * Q_W;
	localparam int CNT_W     = 20;
	localparam int ADDR_W    = 5;
	localparam int FRAC_W    = 28;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [2:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [2:0] REG_REAL_STEP   = 3'd2;
	localparam logic [2:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT  = 3'd4;

	localparam logic signed [Q_W-1:0] RST_ORIGIN = -32'sd536870912;
	localparam logic signed [Q_W-1:0] RST_STEP   = 32'sd2101256;
	localparam logic [CNT_W-1:0]      RST_LIMIT  = 20'd200000;

	// 4.0 in Q8.56.
	localparam logic [PROD_W-1:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

	localparam logic signed [PROD_W-1:0] Q_MAX64 = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] Q_MIN64 = -64'sd2147483648;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_R,
		ST_MAP_I,
		ST_MAP_D,
		ST_RR,
		ST_II,
		ST_RI,
		ST_UPD,
		ST_DONE
	} mbe_state_t;

	// Clamp a wide signed value to the Q4.28 range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX64) begin
			r = Q_MAX64[Q_W-1:0];
		end else if (v < Q_MIN64) begin
			r = Q_MIN64[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/mandelbrot_escape_time_top.sv]
`timescale 1ns / 1ps

// A pixel runs through ST_MAP_R, ST_MAP_I and ST_MAP_D, then iterates through ST_RR, ST_II,
// ST_RI and ST_UPD until it escapes or reaches the limit, and ends in ST_DONE.
// One shared 32x32 multiplier, used three times in each iteration, sets the pace.
// busy stays high through the done cycle, so a new pixel is taken only once the last one
// is finished. done marks the count word for one cycle; no stall exists.
// Reset is asynchronous, active low, and restores the default window and a limit of 200000.
module mandelbrot_escape_time_top
	import mbe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Command side.
	input  logic             start,
	output logic             busy,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	// Result side.
	output logic             done,
	output logic [CNT_W-1:0] iteration_count,
	// Configuration port.
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [Q_W-1:0]   pwdata,
	output logic [Q_W-1:0]   prdata,
	output logic             pready
);

	// Configuration registers.
	logic signed [Q_W-1:0] real_origin_q;
	logic signed [Q_W-1:0] imag_origin_q;
	logic signed [Q_W-1:0] real_step_q;
	logic signed [Q_W-1:0] imag_step_q;
	logic [CNT_W-1:0]      iter_limit_q;

	// Sequencer.
	mbe_state_t state_q, state_d;

	// Datapath registers.
	logic [IDX_W-1:0]         row_q, col_q;
	logic signed [Q_W-1:0]    cr_q, ci_q, zr_q, zi_q;
	logic signed [PROD_W-1:0] prod_q, rr_q, diff_q;
	logic [CNT_W-1:0]         count_q;

	// Shared multiplier operands.
	logic signed [Q_W-1:0] mul_a, mul_b;

	logic             cfg_wr;
	logic [2:0]       cfg_idx;
	logic [PROD_W-1:0] mag_sum;
	logic             escaped;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[ADDR_W-1:2];

	// The write takes effect at the end of the access phase. Addresses past the
	// last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= RST_ORIGIN;
			imag_origin_q <= RST_ORIGIN;
			real_step_q   <= RST_STEP;
			imag_step_q   <= RST_STEP;
			iter_limit_q  <= RST_LIMIT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_REAL_ORIGIN: real_origin_q <= pwdata;
				REG_IMAG_ORIGIN: imag_origin_q <= pwdata;
				REG_REAL_STEP:   real_step_q   <= pwdata;
				REG_IMAG_STEP:   imag_step_q   <= pwdata;
				REG_ITER_LIMIT:  iter_limit_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back; unused bits and unmapped addresses read as zero.
	always_comb begin
		unique case (cfg_idx)
			REG_REAL_ORIGIN: prdata = real_origin_q;
			REG_IMAG_ORIGIN: prdata = imag_origin_q;
			REG_REAL_STEP:   prdata = real_step_q;
			REG_IMAG_STEP:   prdata = imag_step_q;
			REG_ITER_LIMIT:  prdata = {{(Q_W-CNT_W){1'b0}}, iter_limit_q};
			default:         prdata = '0;
		endcase
	end

	// Both squares are non-negative and at most 2^62, so the sum cannot wrap. The
	// square of the real part sits in rr_q and the imaginary one in prod_q while
	// the sequencer is in ST_RI.
	assign mag_sum = rr_q + prod_q;
	assign escaped = (mag_sum >= ESCAPE_BOUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. Each iteration first checks the count against the limit,
	// then forms the two squares, tests for escape, and finally forms the cross
	// product and updates z.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_MAP_R;
			ST_MAP_R: state_d = ST_MAP_I;
			ST_MAP_I: state_d = ST_MAP_D;
			ST_MAP_D: state_d = ST_RR;
			ST_RR:    state_d = (count_q >= iter_limit_q) ? ST_DONE : ST_II;
			ST_II:    state_d = ST_RI;
			ST_RI:    state_d = escaped ? ST_DONE : ST_UPD;
			ST_UPD:   state_d = ST_RR;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs and multiplier operand selection.
	always_comb begin
		busy  = (state_q != ST_IDLE);
		done  = (state_q == ST_DONE);
		mul_a = zr_q;
		mul_b = zr_q;
		unique case (state_q)
			ST_MAP_R: begin
				mul_a = $signed({{(Q_W-IDX_W){1'b0}}, row_q});
				mul_b = real_step_q;
			end
			ST_MAP_I: begin
				mul_a = $signed({{(Q_W-IDX_W){1'b0}}, col_q});
				mul_b = imag_step_q;
			end
			ST_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			ST_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end

	assign iteration_count = count_q;

	// Datapath. The product register follows the multiplier every cycle; the
	// sequencer picks up the value one state after choosing the operands.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					row_q <= row_index;
					col_q <= col_index;
				end
			end
			ST_MAP_R: begin
				count_q <= '0;
			end
			ST_MAP_I: begin
				cr_q <= sat_q(prod_q + PROD_W'(real_origin_q));
				zr_q <= sat_q(prod_q + PROD_W'(real_origin_q));
			end
			ST_MAP_D: begin
				ci_q <= sat_q(prod_q + PROD_W'(imag_origin_q));
				zi_q <= sat_q(prod_q + PROD_W'(imag_origin_q));
			end
			ST_II: begin
				rr_q <= prod_q;
			end
			ST_RI: begin
				diff_q <= rr_q - prod_q;
			end
			ST_UPD: begin
				zr_q    <= sat_q((diff_q >>> FRAC_W) + PROD_W'(cr_q));
				zi_q    <= sat_q((prod_q >>> (FRAC_W - 1)) + PROD_W'(ci_q));
				count_q <= count_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule
